/* src/shdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_pkg
// Types and constants shared by the sync-header packet deframer modules.
// ----------------------------------------------------------------------------
package shdf_pkg;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFD;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hDF;

  // Input function codes.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_SYNC_ERR = 2'd1;
  localparam logic [1:0] ST_DONE     = 2'd2;

  // Parser phases.
  localparam logic [3:0] PH_SYNC1 = 4'd0;
  localparam logic [3:0] PH_SYNC2 = 4'd1;
  localparam logic [3:0] PH_NODE  = 4'd2;
  localparam logic [3:0] PH_FLAGS = 4'd3;
  localparam logic [3:0] PH_ADDR  = 4'd4;
  localparam logic [3:0] PH_LEN   = 4'd5;
  localparam logic [3:0] PH_HCHK  = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_TCHK  = 4'd8;

  // One received item.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } shdf_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] node_id;
    logic [7:0] flag_bits;
    logic [7:0] register_address;
    logic [7:0] payload_length;
    logic [7:0] header_check;
    logic [7:0] total_check;
  } shdf_out_t;

  // Sync byte settings handed to the parser.
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } shdf_cfg_t;

endpackage
`default_nettype wire

/* src/shdf_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_cfg
// Configuration registers holding the two expected sync byte values.
// ----------------------------------------------------------------------------
module shdf_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [shdf_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [7:0]                    wr_data,
  output shdf_pkg::shdf_cfg_t                cfg
);
  import shdf_pkg::*;

  logic [7:0] sync_first;
  logic [7:0] sync_second;

  // Register writes; every index in range names a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SYNC_FIRST:  sync_first  <= wr_data;
        REG_SYNC_SECOND: sync_second <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.sync_first  = sync_first;
  assign cfg.sync_second = sync_second;

endmodule
`default_nettype wire

/* src/shdf_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_in_stage
// Input register: captures each accepted request and holds it until the
// parser stage takes it.
// ----------------------------------------------------------------------------
module shdf_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire shdf_pkg::shdf_in_t in_data,
  output logic                    item_valid,
  output shdf_pkg::shdf_in_t      item,
  input  wire logic               item_take
);
  import shdf_pkg::*;

  logic load;

  // The register can load when empty or when its item leaves this cycle.
  assign in_stall = item_valid && !item_take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

endmodule
`default_nettype wire

/* src/shdf_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_parse
// Packet phase machine, captured header fields and the result register.
// ----------------------------------------------------------------------------
module shdf_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire shdf_pkg::shdf_cfg_t cfg,
  input  wire logic                item_valid,
  input  wire shdf_pkg::shdf_in_t  item,
  output logic                     item_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output shdf_pkg::shdf_out_t      out_data
);
  import shdf_pkg::*;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [7:0] saved_node_id;
  logic [7:0] saved_node_id_next;
  logic [7:0] saved_flags;
  logic [7:0] saved_flags_next;
  logic [7:0] saved_address;
  logic [7:0] saved_address_next;
  logic [7:0] saved_length;
  logic [7:0] saved_length_next;
  logic [7:0] saved_header_check;
  logic [7:0] saved_header_check_next;
  logic [7:0] payload_count;
  logic [7:0] payload_count_next;
  shdf_out_t  result;

  // The result register is free when empty or being taken this cycle.
  assign item_take = item_valid && (!out_valid || !out_stall);

  // Next state and result for the item in the input register.
  always_comb begin
    phase_next              = phase;
    saved_node_id_next      = saved_node_id;
    saved_flags_next        = saved_flags;
    saved_address_next      = saved_address;
    saved_length_next       = saved_length;
    saved_header_check_next = saved_header_check;
    payload_count_next      = payload_count;
    result                  = '0;
    result.status           = ST_BUSY;

    if (item.func == FUNC_RESTART) begin
      phase_next = PH_SYNC1;
    end else begin
      unique case (phase)
        PH_SYNC2: begin
          if (item.rx_byte == cfg.sync_second) begin
            phase_next = PH_NODE;
          end else begin
            phase_next    = PH_SYNC1;
            result.status = ST_SYNC_ERR;
          end
        end
        PH_NODE: begin
          saved_node_id_next = item.rx_byte;
          phase_next         = PH_FLAGS;
        end
        PH_FLAGS: begin
          saved_flags_next = item.rx_byte;
          phase_next       = PH_ADDR;
        end
        PH_ADDR: begin
          saved_address_next = item.rx_byte;
          phase_next         = PH_LEN;
        end
        PH_LEN: begin
          saved_length_next  = item.rx_byte;
          payload_count_next = '0;
          phase_next         = PH_HCHK;
        end
        PH_HCHK: begin
          saved_header_check_next = item.rx_byte;
          phase_next = (saved_length == 8'd0) ? PH_TCHK : PH_DATA;
        end
        PH_DATA: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = item.rx_byte;
          result.payload_index = payload_count;
          payload_count_next   = payload_count + 8'd1;
          if (payload_count_next >= saved_length) begin
            phase_next = PH_TCHK;
          end
        end
        PH_TCHK: begin
          result.total_check = item.rx_byte;
          result.status      = ST_DONE;
          phase_next         = PH_SYNC1;
        end
        default: begin
          // Hunting for the first sync byte; unused phases behave the same.
          if (item.rx_byte == cfg.sync_first) begin
            phase_next = PH_SYNC2;
          end else begin
            phase_next    = PH_SYNC1;
            result.status = ST_SYNC_ERR;
          end
        end
      endcase
    end

    // Captured fields always show the state after this item.
    result.node_id          = saved_node_id_next;
    result.flag_bits        = saved_flags_next;
    result.register_address = saved_address_next;
    result.payload_length   = saved_length_next;
    result.header_check     = saved_header_check_next;
  end

  // Packet state, updated as each item passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SYNC1;
      saved_node_id      <= '0;
      saved_flags        <= '0;
      saved_address      <= '0;
      saved_length       <= '0;
      saved_header_check <= '0;
      payload_count      <= '0;
    end else if (item_take) begin
      phase              <= phase_next;
      saved_node_id      <= saved_node_id_next;
      saved_flags        <= saved_flags_next;
      saved_address      <= saved_address_next;
      saved_length       <= saved_length_next;
      saved_header_check <= saved_header_check_next;
      payload_count      <= payload_count_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

/* src/sync_header_packet_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_packet_deframer
// Receive-side deframer for sync-headed serial packets, one byte per request.
//
//   Channel   Handshake             Payload
//   --------  --------------------  -----------------------------------
//   in        in_valid / in_stall   in_data   (func, rx_byte)
//   out       out_valid / out_stall out_data  (status, payload, header)
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request passes through an input register and the phase machine into
// a result register; it sustains one request per cycle unless out stalls.
// The phase, captured field and payload count registers form a loop that
// closes through the phase machine.
// Reset is synchronous; it restores the sync bytes to FD and DF hex and
// clears phase and captured fields. A stall on out holds the result and
// backs up into in_stall once the input register is also full.
// ----------------------------------------------------------------------------
module sync_header_packet_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire shdf_pkg::shdf_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output shdf_pkg::shdf_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [shdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import shdf_pkg::*;

  shdf_cfg_t cfg;
  logic      item_valid;
  shdf_in_t  item;
  logic      item_take;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  shdf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  shdf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  shdf_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
